FILE: hw/rtl/tcs_pkg.sv
// Shared types and constants for the telnet command stripper.
// Used by the parser, the queue, the emitter and the top level.
package tcs_pkg;

  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_IAC  = 8'd255;

  // Verb codes relative to WILL, as kept in the parser.
  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_DO   = 2'd2;

  // Options that are accepted without a reply.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;

  localparam int TCS_QDEPTH = 4;
  localparam int TCS_QPTR_W = $clog2(TCS_QDEPTH);
  localparam int TCS_QCNT_W = $clog2(TCS_QDEPTH + 1);

  // One queued job for the emitter: either a payload byte or a refusal.
  typedef struct packed {
    logic       refuse;  // 1: send IAC, verb, data to the peer
    logic [7:0] verb;    // reply verb byte (DONT or WONT) for a refusal
    logic [7:0] data;    // payload byte, or the refused option
  } tcs_entry_t;

  // Queue status seen by the parser and the emitter.
  typedef struct packed {
    logic full;
    logic nonempty;
  } tcs_qstat_t;

endpackage

FILE: hw/rtl/telnet_command_stripper.sv
// Telnet command stripper: removes IAC sequences from a received byte
// stream and produces refusals for unsupported options.
//
// Input channel rx_valid / rx_stall / rx_byte carries bytes from the peer.
// Output channel out_valid / out_stall carries out_byte, to_peer and last:
// to_peer low is payload for the remote host, high is a reply byte for the
// peer, and last marks the final output byte caused by one input item.
// An input item is taken every cycle while the internal queue of four jobs
// has room. Payload passes through a queue slot, then the output register.
// A refusal (IAC DONT opt or IAC WONT opt) holds the output register for its
// three bytes in turn. The single output register sends one byte per cycle
// while the queue holds jobs and out_stall is low.
// When the receiver asserts out_stall, the output register holds its byte,
// the queue fills, and rx_stall rises once four jobs are waiting.
// Reset clears the parse phase, the queue pointers and the output valid.
// Depends on tcs_pkg, tcs_parse, tcs_queue and tcs_emit.
module telnet_command_stripper
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       to_peer,
  output logic       last
);

  tcs_qstat_t qstat;
  tcs_entry_t push_entry;
  tcs_entry_t head;
  logic       push;
  logic       pop;

  tcs_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_byte    (rx_byte),
    .rx_stall   (rx_stall),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  tcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  tcs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .to_peer   (to_peer),
    .last      (last)
  );

endmodule

FILE: hw/rtl/tcs_parse.sv
// Front part: accepts received bytes and classifies IAC sequences.
// Depends on tcs_pkg; pushes jobs into tcs_queue.
module tcs_parse
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic [7:0] rx_byte,
  output logic       rx_stall,
  input  tcs_qstat_t qstat,
  output logic       push,
  output tcs_entry_t push_entry
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_IAC,
    PH_OPTION
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] pending_verb, pending_verb_next;
  logic       accept;
  logic       opt_ok;

  assign rx_stall = qstat.full;
  assign accept   = rx_valid && !qstat.full;
  assign opt_ok   = (rx_byte == OPT_BINARY) || (rx_byte == OPT_ECHO) || (rx_byte == OPT_SGA);

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    push              = 1'b0;
    push_entry        = '{refuse: 1'b0, verb: CMD_DONT, data: rx_byte};
    if (accept) begin
      unique case (phase)
        PH_IAC: begin
          phase_next = PH_DATA;
          if (rx_byte == CMD_IAC) begin
            push = 1'b1;
          end else if (rx_byte >= CMD_WILL) begin
            pending_verb_next = 2'(rx_byte - CMD_WILL);
            phase_next        = PH_OPTION;
          end
        end
        PH_OPTION: begin
          phase_next = PH_DATA;
          if (!opt_ok && pending_verb == VERB_WILL) begin
            push       = 1'b1;
            push_entry = '{refuse: 1'b1, verb: CMD_DONT, data: rx_byte};
          end else if (!opt_ok && pending_verb == VERB_DO) begin
            push       = 1'b1;
            push_entry = '{refuse: 1'b1, verb: CMD_WONT, data: rx_byte};
          end
        end
        default: begin
          if (rx_byte == CMD_IAC) begin
            phase_next = PH_IAC;
          end else begin
            phase_next = PH_DATA;
            push       = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      pending_verb <= 2'd0;
    end else begin
      phase        <= phase_next;
      pending_verb <= pending_verb_next;
    end
  end

endmodule

FILE: hw/rtl/tcs_queue.sv
// Short job queue between the parser and the emitter.
// Depends on tcs_pkg for the entry type and depth.
module tcs_queue
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tcs_entry_t push_entry,
  input  logic       pop,
  output tcs_entry_t head,
  output tcs_qstat_t qstat
);

  tcs_entry_t            slots [TCS_QDEPTH];
  logic [TCS_QPTR_W-1:0] wr_ptr;
  logic [TCS_QPTR_W-1:0] rd_ptr;
  logic [TCS_QCNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign qstat.full     = (count == TCS_QCNT_W'(TCS_QDEPTH));
  assign qstat.nonempty = (count != '0);
  assign do_push        = push && !qstat.full;
  assign do_pop         = pop && qstat.nonempty;
  assign head           = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tcs_emit.sv
// Back part: turns queued jobs into output bytes through an output register.
// Depends on tcs_pkg; pops jobs from tcs_queue.
module tcs_emit
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  tcs_entry_t head,
  input  tcs_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       to_peer,
  output logic       last
);

  logic [1:0] step;
  logic       load;
  logic       job_done;
  logic [7:0] byte_next;

  // The output register takes a new byte when it is empty or being taken.
  assign load     = !out_valid || !out_stall;
  assign job_done = !head.refuse || (step == 2'd2);
  assign pop      = load && qstat.nonempty && job_done;

  always_comb begin
    byte_next = head.data;
    if (head.refuse) begin
      unique case (step)
        2'd0:    byte_next = CMD_IAC;
        2'd1:    byte_next = head.verb;
        default: byte_next = head.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      to_peer  <= head.refuse;
      last     <= job_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 2'd0;
    end else if (load) begin
      out_valid <= qstat.nonempty;
      if (qstat.nonempty) begin
        step <= job_done ? 2'd0 : step + 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/tcs_checker.sv
// Port-level checks for the telnet command stripper, bound to the top level.
// Depends on tcs_pkg for the command codes.
module tcs_checker
  import tcs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       to_peer,
  input logic       last
);

  // Payload always comes from a single input item.
  a_payload_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !to_peer |-> last)
    else $error("payload byte without last");

  // A reply IAC is followed at once by the reply verb.
  a_reply_verb: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && to_peer && !last && out_byte == CMD_IAC
    |=> out_valid && to_peer && !last && (out_byte == CMD_WONT || out_byte == CMD_DONT))
    else $error("reply IAC not followed by verb");

  // The reply verb is followed at once by the option byte that ends the reply.
  a_reply_opt: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && to_peer && !last
      && (out_byte == CMD_WONT || out_byte == CMD_DONT)
    |=> out_valid && to_peer && last)
    else $error("reply verb not followed by option");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall
    |=> out_valid && $stable(out_byte) && $stable(to_peer) && $stable(last))
    else $error("stalled output changed");

endmodule

bind telnet_command_stripper tcs_checker u_tcs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .to_peer   (to_peer),
  .last      (last)
);

FILE: tb/telnet_command_stripper_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the telnet command stripper: follows the received byte stream,
// predicts the payload and refusal bytes and compares them with the output channel.
// Depends on tcs_pkg for the command and option codes.
module telnet_command_stripper_checker
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       to_peer,
  input  logic       last,
  output int         fail_count,
  output int         pending_results,
  output int         checked_results,
  output int         reply_results
);

  typedef enum logic [1:0] {
    PH_DATA   = 2'd0,
    PH_IAC    = 2'd1,
    PH_OPTION = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       peer;
    logic       fin;
  } out_beat_t;

  parse_phase_t phase = PH_DATA;
  logic [1:0]   pending_verb = 2'd0;
  out_beat_t    expected_beats[$];
  int           fails = 0;
  int           checked = 0;
  int           replies = 0;
  int           pending = 0;

  assign fail_count      = fails;
  assign pending_results = pending;
  assign checked_results = checked;
  assign reply_results   = replies;

  task automatic push_beat(input logic [7:0] data, input logic peer, input logic fin);
    out_beat_t beat;
    beat.data = data;
    beat.peer = peer;
    beat.fin  = fin;
    expected_beats.push_back(beat);
  endtask

  // A refusal goes back to the peer as IAC, reply verb, option.
  task automatic queue_refusal(input logic [7:0] verb, input logic [7:0] opt);
    push_beat(CMD_IAC, 1'b1, 1'b0);
    push_beat(verb, 1'b1, 1'b0);
    push_beat(opt, 1'b1, 1'b1);
  endtask

  task automatic strip_rx_byte(input logic [7:0] b);
    case (phase)
      PH_IAC: begin
        phase = PH_DATA;
        if (b == CMD_IAC) begin
          push_beat(CMD_IAC, 1'b0, 1'b1);
        end else if (b >= CMD_WILL && b <= CMD_DONT) begin
          pending_verb = 2'(b - CMD_WILL);
          phase = PH_OPTION;
        end
      end
      PH_OPTION: begin
        phase = PH_DATA;
        // Any option byte is consumed; only unsupported WILL and DO get a reply.
        if (!(b == OPT_BINARY || b == OPT_ECHO || b == OPT_SGA)) begin
          if (pending_verb == VERB_WILL) begin
            queue_refusal(CMD_DONT, b);
          end else if (pending_verb == VERB_DO) begin
            queue_refusal(CMD_WONT, b);
          end
        end
      end
      default: begin
        phase = PH_DATA;
        if (b == CMD_IAC) begin
          phase = PH_IAC;
        end else begin
          push_beat(b, 1'b0, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val, inout bit bad);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    out_beat_t beat;
    bit        bad;
    if (rst) begin
      phase = PH_DATA;
      pending_verb = 2'd0;
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected output item: out_byte %0d to_peer %0d last %0d",
                 out_byte, to_peer, last);
          fails++;
        end else begin
          beat = expected_beats.pop_front();
          bad = 1'b0;
          check_field("out_byte", beat.data, out_byte, bad);
          check_field("to_peer", 8'(beat.peer), 8'(to_peer), bad);
          check_field("last", 8'(beat.fin), 8'(last), bad);
          if (bad) fails++;
          checked++;
          if (beat.peer) replies++;
        end
      end
      if (rx_valid && !rx_stall) strip_rx_byte(rx_byte);
    end
    pending = expected_beats.size();
  end

endmodule

FILE: tb/tb_telnet_command_stripper.sv
`timescale 1ns / 1ps
// Testbench top for the telnet command stripper: clock, reset, byte stimulus
// under several flow-control phases, and the verdict.
// Depends on tcs_pkg, telnet_command_stripper and telnet_command_stripper_checker.
module tb_telnet_command_stripper;
  import tcs_pkg::*;

  localparam int         RUN_LIMIT   = 200000;
  localparam int         PHASE_ITEMS = 37;
  localparam logic [7:0] CMD_NOP     = 8'd241;
  localparam logic [7:0] CMD_SB      = 8'd250;
  localparam logic [7:0] OPT_TTYPE   = 8'd24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic [7:0] rx_byte = 8'd0;
  logic       out_stall = 1'b0;
  logic       rx_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       to_peer;
  logic       last;

  int fail_count;
  int pending_results;
  int checked_results;
  int reply_results;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  telnet_command_stripper uut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .to_peer  (to_peer),
    .last     (last)
  );

  telnet_command_stripper_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .to_peer        (to_peer),
    .last           (last),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .checked_results(checked_results),
    .reply_results  (reply_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // The payload stays put until the item is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (rx_stall);
    bytes_sent++;
  endtask

  task automatic send_negotiation(input logic [7:0] verb, input logic [7:0] opt);
    send_byte(CMD_IAC);
    send_byte(verb);
    send_byte(opt);
  endtask

  function automatic logic [7:0] random_option();
    case ($urandom_range(5))
      0: return OPT_BINARY;
      1: return OPT_ECHO;
      2: return OPT_SGA;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed command sequences with random content, plus raw noise.
  task automatic send_random_stream(input int n_items);
    int         start;
    int         kind;
    logic [7:0] verb;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        send_byte(8'($urandom_range(254)));
      end else if (kind < 50) begin
        send_byte(CMD_IAC);
        send_byte(CMD_IAC);
      end else if (kind < 82) begin
        verb = 8'(CMD_WILL + $urandom_range(3));
        send_negotiation(verb, random_option());
      end else if (kind < 92) begin
        send_byte(CMD_IAC);
        send_byte(8'($urandom_range(250)));
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: plain bytes 0, 127 and 128, escaped IAC, commands that are
    // dropped, WILL and DO with accepted and refused options, and WONT and DONT.
    send_byte(8'd0);
    send_byte(8'd127);
    send_byte(8'd128);
    send_byte(CMD_IAC);
    send_byte(CMD_IAC);
    send_byte(CMD_IAC);
    send_byte(CMD_NOP);
    send_byte(CMD_IAC);
    send_byte(CMD_SB);
    send_byte(8'd42);
    send_negotiation(CMD_WILL, OPT_BINARY);
    send_negotiation(CMD_DO, OPT_ECHO);
    send_negotiation(CMD_WILL, OPT_SGA);
    send_negotiation(CMD_WILL, OPT_TTYPE);
    send_negotiation(CMD_DO, CMD_IAC);
    send_negotiation(CMD_WONT, 8'd5);
    send_negotiation(CMD_DONT, 8'd7);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      send_random_stream(PHASE_ITEMS);
    end

    rx_valid <= 1'b0;
    stall_pct = 0;
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (pending_results != 0) begin
      $error("%0d expected output items never arrived", pending_results);
    end
    $display("Sent %0d received bytes under four flow-control mixes; checked %0d output",
             bytes_sent, checked_results);
    $display("items, %0d of them refusal bytes toward the peer.", reply_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: telnet_command_stripper.f
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_parse.sv
hw/rtl/tcs_queue.sv
hw/rtl/tcs_emit.sv
hw/rtl/telnet_command_stripper.sv
hw/rtl/tcs_checker.sv
tb/telnet_command_stripper_checker.sv
tb/tb_telnet_command_stripper.sv
